// File: rtl/csp_pkg.sv
// Shared widths, register indexes, sideband structs and helpers for the
// cylinder surface projection pipeline. No dependencies.
`default_nettype none

package csp_pkg;

    // Field and datapath widths
    localparam int PW    = 32;          // point / center / closest
    localparam int AXW   = 18;          // axis and normal components
    localparam int RADW  = 31;          // radius
    localparam int DW    = PW + 1;      // point minus center
    localparam int DPW   = DW + AXW;    // axis * d products
    localparam int DOTW  = DPW + 2;     // sum of three products
    localparam int TW    = DOTW - 16;   // projection t, Q21.16
    localparam int TAW   = TW + AXW;    // t * axis
    localparam int AW    = TAW - 16 + 1; // axis point, wide
    localparam int RW    = AW + 1;      // radial offset
    localparam int PSW   = 6;           // bit position within RW
    localparam int MW    = 31;          // normalized magnitude
    localparam int NORM_TOP = MW - 1;   // target leading bit position
    localparam int SQW   = 64;          // sum of squares
    localparam int LW    = SQW / 2;     // square root
    localparam int QW    = 17;          // quotient magnitude
    localparam int NUMW  = MW + 16 + 2; // dividend and remainder
    localparam int RPW   = RADW + 1 + AXW; // radius * normal
    localparam int RND   = 32768;       // half LSB for Q16.16 rounding

    localparam int SQ_STAGES  = LW;
    localparam int DIV_STAGES = QW + 1;
    localparam int FRONT_STAGES = 10;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY = FRONT_STAGES + SQ_STAGES + DIV_STAGES + BACK_STAGES;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    typedef enum logic [CFG_IW-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_RADIUS   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         neg;
        logic               zero;
        logic [2:0][MW-1:0] ms;
    } t_sqrt_side;

    typedef struct packed {
        logic [2:0][AW-1:0] a;
        logic [2:0]         neg;
        logic               zero;
    } t_div_side;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [PSW-1:0] msb_pos(input logic [RW-1:0] v);
        logic [PSW-1:0] p;
        p = '0;
        for (int k = 0; k < RW; k++) begin
            if (v[k]) begin
                p = PSW'(k);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: rtl/csp_isqrt.sv
// Pipelined integer square root, one result bit per stage, sideband carried.
// Depends on csp_pkg.
`default_nettype none

module csp_isqrt
    import csp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [SQW-1:0]   i_x,
    input  wire t_sqrt_side       i_side,
    output logic                  o_valid,
    output logic [LW-1:0]         o_root,
    output t_sqrt_side            o_side
);

    logic [SQW-1:0] r_x   [SQ_STAGES];
    logic [SQW-1:0] r_res [SQ_STAGES];
    logic           r_v   [SQ_STAGES];
    t_sqrt_side     r_side[SQ_STAGES];

    for (genvar i = 0; i < SQ_STAGES; i++) begin : g_st
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * i);
        logic [SQW-1:0] x_in;
        logic [SQW-1:0] res_in;
        logic           v_in;
        t_sqrt_side     s_in;
        logic [SQW-1:0] trial;

        if (i == 0) begin : g_first
            assign x_in   = i_x;
            assign res_in = '0;
            assign v_in   = i_valid;
            assign s_in   = i_side;
        end else begin : g_next
            assign x_in   = r_x[i-1];
            assign res_in = r_res[i-1];
            assign v_in   = r_v[i-1];
            assign s_in   = r_side[i-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[i] <= s_in;
            if (x_in >= trial) begin
                r_x[i]   <= x_in - trial;
                r_res[i] <= (res_in >> 1) + BIT;
            end else begin
                r_x[i]   <= x_in;
                r_res[i] <= res_in >> 1;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_res[SQ_STAGES-1][LW-1:0];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/csp_div.sv
// Pipelined restoring divider for the three normal components, rounded
// half up, one quotient bit per stage after the dividend stage. Depends on csp_pkg.
`default_nettype none

module csp_div
    import csp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [2:0][MW-1:0] i_m,
    input  wire logic [LW-1:0]      i_len,
    input  wire t_div_side          i_side,
    output logic                    o_valid,
    output logic [2:0][QW-1:0]      o_q,
    output t_div_side               o_side
);

    logic [NUMW-1:0] r_rem [DIV_STAGES][3];
    logic [QW-1:0]   r_q   [DIV_STAGES][3];
    logic [LW-1:0]   r_len [DIV_STAGES];
    logic            r_v   [DIV_STAGES];
    t_div_side       r_side[DIV_STAGES];

    // Form the dividend m * 2^16 + floor(len / 2).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len[0]  <= i_len;
        r_side[0] <= i_side;
        for (int j = 0; j < 3; j++) begin
            r_rem[0][j] <= NUMW'({i_m[j], 16'b0}) + NUMW'(i_len >> 1);
            r_q[0][j]   <= '0;
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_st
        localparam int BP = QW - k;
        logic [NUMW-1:0] dvs;
        assign dvs = NUMW'(r_len[k-1]) << BP;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_len[k]  <= r_len[k-1];
            r_side[k] <= r_side[k-1];
            for (int j = 0; j < 3; j++) begin
                if (r_rem[k-1][j] >= dvs) begin
                    r_rem[k][j] <= r_rem[k-1][j] - dvs;
                    r_q[k][j]   <= r_q[k-1][j] | (QW'(1) << BP);
                end else begin
                    r_rem[k][j] <= r_rem[k-1][j];
                    r_q[k][j]   <= r_q[k-1][j];
                end
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            o_q[j] = r_q[DIV_STAGES-1][j];
        end
    end

endmodule

`default_nettype wire

// File: rtl/cylinder_surface_projection_top.sv
// Top level of the closest-point-on-cylinder pipeline: configuration
// registers, projection front end, normalization and output stages.
// Depends on csp_pkg, csp_isqrt and csp_div.
`default_nettype none

// Closest point on an infinite cylinder, signed Q16.16. Raise i_start with a
// point while o_busy is low; o_busy is high only during reset, so a new point
// can be transferred on every clock. Each point yields exactly one result,
// marked by a one-cycle o_valid strobe, in input order; the receiver cannot
// stall and must take it then. The pipeline is made of a ten-stage
// projection and scaling front end, a 32-stage square root (one root bit per
// stage), an 18-stage divider (a dividend stage, then one quotient bit per
// stage) and three output stages for sign, radius scaling and saturation.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata while
// no point is in flight; unknown indexes are ignored. A point exactly on the
// axis takes its normal from the axis cross product with the x axis (or the
// y axis when that is zero); with a zero axis, a point at the center gets a
// zero normal.
module cylinder_surface_projection_top
    import csp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic signed [PW-1:0]   i_point_x,
    input  wire logic signed [PW-1:0]   i_point_y,
    input  wire logic signed [PW-1:0]   i_point_z,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IW-1:0]      i_cfg_idx,
    input  wire logic [CFG_DW-1:0]      i_cfg_wdata,
    output logic                        o_valid,
    output logic signed [PW-1:0]        o_closest_x,
    output logic signed [PW-1:0]        o_closest_y,
    output logic signed [PW-1:0]        o_closest_z,
    output logic signed [AXW-1:0]       o_normal_x,
    output logic signed [AXW-1:0]       o_normal_y,
    output logic signed [AXW-1:0]       o_normal_z
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [PW-1:0]  r_c  [3];
    logic signed [AXW-1:0] r_ax [3];
    logic [RADW-1:0]       r_rad;
    logic                  r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c[0] <= '0;
            r_c[1] <= '0;
            r_c[2] <= '0;
            r_ax[0] <= '0;
            r_ax[1] <= '0;
            r_ax[2] <= AXW'(65536);
            r_rad   <= RADW'(65536);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X: r_c[0]  <= i_cfg_wdata;
                REG_CENTER_Y: r_c[1]  <= i_cfg_wdata;
                REG_CENTER_Z: r_c[2]  <= i_cfg_wdata;
                REG_AXIS_X:   r_ax[0] <= i_cfg_wdata[AXW-1:0];
                REG_AXIS_Y:   r_ax[1] <= i_cfg_wdata[AXW-1:0];
                REG_AXIS_Z:   r_ax[2] <= i_cfg_wdata[AXW-1:0];
                REG_RADIUS:   r_rad   <= i_cfg_wdata[RADW-1:0];
                default:      ;
            endcase
        end
    end

    // Hold busy only while in reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;

    logic w_accept;
    assign w_accept = i_start && !r_busy;

    // ---------------------------------------------------------------
    // Front end valid chain
    // ---------------------------------------------------------------
    logic [FRONT_STAGES-1:0] r_vf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= '0;
        end else begin
            r_vf <= {r_vf[FRONT_STAGES-2:0], w_accept};
        end
    end

    // Stage 1: offset from the center.
    logic signed [PW-1:0] w_p [3];
    logic signed [PW-1:0] r_p1 [3];
    logic signed [DW-1:0] r_d1 [3];
    assign w_p[0] = i_point_x;
    assign w_p[1] = i_point_y;
    assign w_p[2] = i_point_z;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_p1[j] <= w_p[j];
            r_d1[j] <= DW'(w_p[j]) - DW'(r_c[j]);
        end
    end

    // Stage 2: axis times offset, per component.
    logic signed [PW-1:0]  r_p2 [3];
    logic signed [DPW-1:0] r_prod2 [3];
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_p2[j]    <= r_p1[j];
            r_prod2[j] <= DPW'(r_d1[j]) * DPW'(r_ax[j]);
        end
    end

    // Stage 3: dot product, rounded to Q21.16.
    logic signed [PW-1:0]   r_p3 [3];
    logic signed [TW-1:0]   r_t3;
    logic signed [DOTW-1:0] w_dot;
    assign w_dot = DOTW'(r_prod2[0]) + DOTW'(r_prod2[1]) + DOTW'(r_prod2[2])
                 + DOTW'(RND);
    always_ff @(posedge i_clk) begin
        r_p3 <= r_p2;
        r_t3 <= w_dot[DOTW-1:16];
    end

    // Stage 4: t times axis.
    logic signed [PW-1:0]  r_p4 [3];
    logic signed [TAW-1:0] r_tp4 [3];
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_p4[j]  <= r_p3[j];
            r_tp4[j] <= TAW'(r_t3) * TAW'(r_ax[j]);
        end
    end

    // Stage 5: axis point and radial offset.
    logic signed [AW-1:0]  r_a5 [3];
    logic signed [RW-1:0]  r_r5 [3];
    logic signed [TAW-1:0] w_tpr [3];
    logic signed [AW-1:0]  w_a5 [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_tpr[j] = r_tp4[j] + TAW'(RND);
            w_a5[j]  = AW'(r_c[j]) + AW'($signed(w_tpr[j][TAW-1:16]));
        end
    end
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_a5[j] <= w_a5[j];
            r_r5[j] <= RW'(r_p4[j]) - RW'(w_a5[j]);
        end
    end

    // Stage 6: pick the radial offset or the fallback cross product, split
    // into sign and magnitude.
    logic signed [AW-1:0] r_a6 [3];
    logic [RW-1:0]        r_m6 [3];
    logic [2:0]           r_neg6;
    logic signed [RW-1:0] w_v [3];
    logic                 w_on_axis;
    always_comb begin
        w_on_axis = (r_r5[0] == '0) && (r_r5[1] == '0) && (r_r5[2] == '0);
        w_v = r_r5;
        if (w_on_axis) begin
            if (r_ax[1] == '0 && r_ax[2] == '0) begin
                w_v[0] = '0;
                w_v[1] = '0;
                w_v[2] = -RW'(r_ax[0]);
            end else begin
                w_v[0] = '0;
                w_v[1] = -RW'(r_ax[2]);
                w_v[2] = RW'(r_ax[1]);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_a6 <= r_a5;
        for (int j = 0; j < 3; j++) begin
            r_neg6[j] <= w_v[j][RW-1];
            r_m6[j]   <= w_v[j][RW-1] ? RW'(-w_v[j]) : RW'(w_v[j]);
        end
    end

    // Stage 7: leading bit of the largest magnitude.
    logic signed [AW-1:0] r_a7 [3];
    logic [RW-1:0]        r_m7 [3];
    logic [2:0]           r_neg7;
    logic                 r_zero7;
    logic [PSW-1:0]       r_pos7;
    logic [RW-1:0]        w_or6;
    assign w_or6 = r_m6[0] | r_m6[1] | r_m6[2];
    always_ff @(posedge i_clk) begin
        r_a7    <= r_a6;
        r_m7    <= r_m6;
        r_neg7  <= r_neg6;
        r_zero7 <= (w_or6 == '0);
        r_pos7  <= msb_pos(w_or6);
    end

    // Stage 8: shift all magnitudes so the largest lands in [2^30, 2^31).
    logic signed [AW-1:0] r_a8 [3];
    logic [MW-1:0]        r_ms8 [3];
    logic [2:0]           r_neg8;
    logic                 r_zero8;
    logic [RW-1:0]        w_sh [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_pos7 >= PSW'(NORM_TOP)) begin
                w_sh[j] = r_m7[j] >> (r_pos7 - PSW'(NORM_TOP));
            end else begin
                w_sh[j] = r_m7[j] << (PSW'(NORM_TOP) - r_pos7);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        r_a8    <= r_a7;
        r_neg8  <= r_neg7;
        r_zero8 <= r_zero7;
        for (int j = 0; j < 3; j++) begin
            r_ms8[j] <= w_sh[j][MW-1:0];
        end
    end

    // Stage 9: squares.
    logic signed [AW-1:0] r_a9 [3];
    logic [MW-1:0]        r_ms9 [3];
    logic [2:0]           r_neg9;
    logic                 r_zero9;
    logic [2*MW-1:0]      r_sq9 [3];
    always_ff @(posedge i_clk) begin
        r_a9    <= r_a8;
        r_ms9   <= r_ms8;
        r_neg9  <= r_neg8;
        r_zero9 <= r_zero8;
        for (int j = 0; j < 3; j++) begin
            r_sq9[j] <= (2*MW)'(r_ms8[j]) * (2*MW)'(r_ms8[j]);
        end
    end

    // Stage 10: sum of squares.
    logic [SQW-1:0] r_sum10;
    t_sqrt_side     r_side10;
    always_ff @(posedge i_clk) begin
        r_sum10 <= SQW'(r_sq9[0]) + SQW'(r_sq9[1]) + SQW'(r_sq9[2]);
        for (int j = 0; j < 3; j++) begin
            r_side10.a[j]  <= r_a9[j];
            r_side10.ms[j] <= r_ms9[j];
        end
        r_side10.neg  <= r_neg9;
        r_side10.zero <= r_zero9;
    end

    // ---------------------------------------------------------------
    // Length and component division
    // ---------------------------------------------------------------
    logic          w_sq_v;
    logic [LW-1:0] w_len;
    t_sqrt_side    w_sq_side;

    csp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vf[FRONT_STAGES-1]),
        .i_x     (r_sum10),
        .i_side  (r_side10),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    t_div_side w_div_in_side;
    assign w_div_in_side.a    = w_sq_side.a;
    assign w_div_in_side.neg  = w_sq_side.neg;
    assign w_div_in_side.zero = w_sq_side.zero;

    logic               w_dv_v;
    logic [2:0][QW-1:0] w_q;
    t_div_side          w_dv_side;

    csp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_v),
        .i_m     (w_sq_side.ms),
        .i_len   (w_len),
        .i_side  (w_div_in_side),
        .o_valid (w_dv_v),
        .o_q     (w_q),
        .o_side  (w_dv_side)
    );

    // ---------------------------------------------------------------
    // Back end
    // ---------------------------------------------------------------
    logic [BACK_STAGES-1:0] r_vb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else begin
            r_vb <= {r_vb[BACK_STAGES-2:0], w_dv_v};
        end
    end

    // Stage B1: apply sign; drop to zero for a zero vector.
    logic signed [AW-1:0]  r_a11 [3];
    logic signed [AXW-1:0] r_n11 [3];
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_a11[j] <= $signed(w_dv_side.a[j]);
            if (w_dv_side.zero) begin
                r_n11[j] <= '0;
            end else if (w_dv_side.neg[j]) begin
                r_n11[j] <= -AXW'(w_q[j]);
            end else begin
                r_n11[j] <= AXW'(w_q[j]);
            end
        end
    end

    // Stage B2: radius times normal.
    logic signed [AW-1:0]  r_a12 [3];
    logic signed [AXW-1:0] r_n12 [3];
    logic signed [RPW-1:0] r_rp12 [3];
    always_ff @(posedge i_clk) begin
        r_a12 <= r_a11;
        r_n12 <= r_n11;
        for (int j = 0; j < 3; j++) begin
            r_rp12[j] <= RPW'($signed({1'b0, r_rad})) * RPW'(r_n11[j]);
        end
    end

    // Stage B3: add to the axis point and saturate.
    logic signed [RPW-1:0] w_rpr [3];
    logic signed [RW-1:0]  w_s [3];
    logic signed [PW-1:0]  w_cl [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_rpr[j] = r_rp12[j] + RPW'(RND);
            w_s[j]   = RW'(r_a12[j]) + RW'($signed(w_rpr[j][RPW-1:16]));
            if (w_s[j][RW-1:PW-1] == '0 || w_s[j][RW-1:PW-1] == '1) begin
                w_cl[j] = w_s[j][PW-1:0];
            end else begin
                w_cl[j] = {w_s[j][RW-1], {(PW-1){~w_s[j][RW-1]}}};
            end
        end
    end

    logic signed [PW-1:0]  r_cl13 [3];
    logic signed [AXW-1:0] r_n13 [3];
    always_ff @(posedge i_clk) begin
        r_cl13 <= w_cl;
        r_n13  <= r_n12;
    end

    assign o_valid     = r_vb[BACK_STAGES-1];
    assign o_closest_x = r_cl13[0];
    assign o_closest_y = r_cl13[1];
    assign o_closest_z = r_cl13[2];
    assign o_normal_x  = r_n13[0];
    assign o_normal_y  = r_n13[1];
    assign o_normal_z  = r_n13[2];

`ifndef ASSERT_OFF
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy high outside reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_valid)
        else $error("result missing at fixed latency");

    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= 65536 && o_normal_x >= -65536 &&
                     o_normal_y <= 65536 && o_normal_y >= -65536 &&
                     o_normal_z <= 65536 && o_normal_z >= -65536))
        else $error("normal component out of unit range");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for cylinder_surface_projection_top: closest point and
// outward normal of query points against an infinite cylinder.
// Depends on csp_pkg and the RTL of the projection pipeline.
`timescale 1ns / 1ps

module tb_top;
    import csp_pkg::*;

    localparam logic [CFG_IW-1:0] REG_SPARE = 3'd7;  // index with no register behind it
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_SHAPE = 100;
    localparam int SHAPES = 7;

    typedef struct {
        logic signed [PW-1:0]  cx, cy, cz;
        logic signed [AXW-1:0] nx, ny, nz;
    } t_surface_hit;

    // Scoreboard: keeps a copy of the cylinder registers, predicts each
    // transfer and compares results in order.
    class surface_board;
        longint cen[3];
        longint axv[3];
        longint rad;
        t_surface_hit pending[$];
        int failures;

        function new();
            cen = '{0, 0, 0};
            axv = '{0, 0, 65536};
            rad = 65536;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
            case (idx)
                REG_CENTER_X: cen[0] = $signed(d);
                REG_CENTER_Y: cen[1] = $signed(d);
                REG_CENTER_Z: cen[2] = $signed(d);
                REG_AXIS_X:   axv[0] = $signed(d[AXW-1:0]);
                REG_AXIS_Y:   axv[1] = $signed(d[AXW-1:0]);
                REG_AXIS_Z:   axv[2] = $signed(d[AXW-1:0]);
                REG_RADIUS:   rad = longint'(d[RADW-1:0]);
                default: ;
            endcase
        endfunction

        // floor((x + 2^15) / 2^16)
        static function longint round_q16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        static function bit [63:0] root_floor(bit [63:0] x);
            bit [63:0] res, b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Unit vector with round-half-up magnitudes; returns 0 for a zero vector.
        static function bit unit_vec(input longint v[3], output longint n[3]);
            bit [63:0] m[3];
            bit [63:0] mx, sq, len, q;
            mx = 0;
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (v[i] < 0) ? -v[i] : v[i];
                if (m[i] > mx) mx = m[i];
                n[i] = 0;
            end
            if (mx == 0) return 0;
            while (mx >= 64'h8000_0000) begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < 64'h4000_0000) begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
            len = root_floor(sq);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 16) + (len >> 1)) / len;
                n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function t_surface_hit project(logic [PW-1:0] px, logic [PW-1:0] py,
                                       logic [PW-1:0] pz);
            longint p[3], a[3], r[3], n[3], f[3];
            longint dot, t, q;
            longint cl[3];
            t_surface_hit h;
            p[0] = $signed(px);
            p[1] = $signed(py);
            p[2] = $signed(pz);
            dot = 0;
            for (int i = 0; i < 3; i++) dot = dot + axv[i] * (p[i] - cen[i]);
            t = round_q16(dot);
            for (int i = 0; i < 3; i++) begin
                a[i] = cen[i] + round_q16(t * axv[i]);
                r[i] = p[i] - a[i];
            end
            if (!unit_vec(r, n)) begin
                // on the axis: fall back to x cross axis, or y cross axis
                f = '{0, -axv[2], axv[1]};
                if (axv[1] == 0 && axv[2] == 0) f = '{axv[2], 0, -axv[0]};
                void'(unit_vec(f, n));
            end
            for (int i = 0; i < 3; i++) begin
                q = a[i] + round_q16(rad * n[i]);
                if (q > 64'sd2147483647) q = 64'sd2147483647;
                if (q < -64'sd2147483648) q = -64'sd2147483648;
                cl[i] = q;
            end
            h.cx = cl[0][PW-1:0];
            h.cy = cl[1][PW-1:0];
            h.cz = cl[2][PW-1:0];
            h.nx = n[0][AXW-1:0];
            h.ny = n[1][AXW-1:0];
            h.nz = n[2][AXW-1:0];
            return h;
        endfunction

        function void note_transfer(logic [PW-1:0] px, logic [PW-1:0] py,
                                    logic [PW-1:0] pz);
            pending.push_back(project(px, py, pz));
        endfunction

        function void check_result(t_surface_hit got);
            t_surface_hit exp_hit;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing pending: %0d %0d %0d / %0d %0d %0d",
                         $time, got.cx, got.cy, got.cz, got.nx, got.ny, got.nz);
                failures++;
                return;
            end
            exp_hit = pending.pop_front();
            if (got.cx !== exp_hit.cx) report_field("closest_x", exp_hit.cx, got.cx);
            if (got.cy !== exp_hit.cy) report_field("closest_y", exp_hit.cy, got.cy);
            if (got.cz !== exp_hit.cz) report_field("closest_z", exp_hit.cz, got.cz);
            if (got.nx !== exp_hit.nx) report_field("normal_x", exp_hit.nx, got.nx);
            if (got.ny !== exp_hit.ny) report_field("normal_y", exp_hit.ny, got.ny);
            if (got.nz !== exp_hit.nz) report_field("normal_z", exp_hit.nz, got.nz);
        endfunction

        function void report_field(string field, longint e, longint g);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, g);
            failures++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [PW-1:0] i_point_x = '0;
    logic signed [PW-1:0] i_point_y = '0;
    logic signed [PW-1:0] i_point_z = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic o_busy, o_valid;
    logic signed [PW-1:0] o_closest_x, o_closest_y, o_closest_z;
    logic signed [AXW-1:0] o_normal_x, o_normal_y, o_normal_z;

    surface_board board = new();
    int idle_pct = 21;   // chance in percent that the sender idles in a given cycle
    int quiet_cycles = 0;

    cylinder_surface_projection_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_closest_x (o_closest_x),
        .o_closest_y (o_closest_y),
        .o_closest_z (o_closest_z),
        .o_normal_x  (o_normal_x),
        .o_normal_y  (o_normal_y),
        .o_normal_z  (o_normal_z)
    );

    always #5 i_clk = ~i_clk;

    // Monitor: note each point transfer, check each result strobe, and
    // count cycles where nothing moves for the watchdog.
    always @(posedge i_clk) begin
        t_surface_hit got;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                board.note_transfer(i_point_x, i_point_y, i_point_z);
            end
            if (o_valid) begin
                got.cx = o_closest_x;
                got.cy = o_closest_y;
                got.cz = o_closest_z;
                got.nx = o_normal_x;
                got.ny = o_normal_y;
                got.nz = o_normal_z;
                board.check_result(got);
            end
            if ((i_start && !o_busy) || o_valid) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Idle for a random number of cycles, then present a point and hold it
    // until transferred.
    task automatic send_point(longint x, longint y, longint z);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_point_x <= x[PW-1:0];
        i_point_y <= y[PW-1:0];
        i_point_z <= z[PW-1:0];
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        board.write_reg(idx, d);
    endtask

    // Drain the pipe, then rewrite every register (plus the spare index).
    task automatic load_cylinder(longint cx, longint cy, longint cz,
                                 longint ax, longint ay, longint az, longint rd);
        i_start <= 1'b0;
        wait_drained();
        @(posedge i_clk);
        write_reg(REG_CENTER_X, cx[31:0]);
        write_reg(REG_CENTER_Y, cy[31:0]);
        write_reg(REG_CENTER_Z, cz[31:0]);
        write_reg(REG_AXIS_X, ax[31:0]);
        write_reg(REG_AXIS_Y, ay[31:0]);
        write_reg(REG_AXIS_Z, az[31:0]);
        write_reg(REG_RADIUS, rd[31:0]);
        write_reg(REG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint any32();
        return longint'($signed($urandom));
    endfunction

    // Random query point: mostly near the center, some anywhere, some on the axis, some at the corners.
    task automatic send_random_point();
        longint p[3], t;
        int kind;
        kind = $urandom_range(0, 9);
        t = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        for (int i = 0; i < 3; i++) begin
            case (kind)
                6, 7:    p[i] = any32();
                8:       p[i] = board.cen[i] + ((t * board.axv[i]) >>> 16);
                9:       p[i] = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
                default: p[i] = board.cen[i] + longint'($urandom_range(0, 1 << 24))
                                - (1 << 23);
            endcase
            p[i] = clamp32(p[i]);
        end
        send_point(p[0], p[1], p[2]);
    endtask

    task automatic load_random_cylinder();
        real x, y, z, l;
        longint c[3], rd;
        int kind;
        for (int i = 0; i < 3; i++) begin
            c[i] = $urandom_range(0, 3) == 0 ? any32()
                 : longint'($urandom_range(0, 1 << 26)) - (1 << 25);
        end
        rd = $urandom_range(0, 3) == 0 ? longint'($urandom & 32'h7fff_ffff)
                                       : longint'($urandom_range(0, 1 << 22));
        kind = $urandom_range(0, 5);
        if (kind == 0) begin
            // arbitrary register bits, unit length not held
            load_cylinder(c[0], c[1], c[2], any32(), any32(), any32(), rd);
        end else if (kind == 1) begin
            case ($urandom_range(0, 2))
                0: load_cylinder(c[0], c[1], c[2], 65536, 0, 0, rd);
                1: load_cylinder(c[0], c[1], c[2], 0, -65536, 0, rd);
                default: load_cylinder(c[0], c[1], c[2], 0, 0, -65536, rd);
            endcase
        end else begin
            x = real'(int'($urandom_range(0, 2000)) - 1000);
            y = real'(int'($urandom_range(0, 2000)) - 1000);
            z = real'(int'($urandom_range(0, 2000)) - 1000);
            l = $sqrt(x * x + y * y + z * z);
            if (l == 0.0) begin
                z = 1.0;
                l = 1.0;
            end
            load_cylinder(c[0], c[1], c[2], $rtoi(x / l * 65536.0),
                          $rtoi(y / l * 65536.0), $rtoi(z / l * 65536.0), rd);
        end
    endtask

    initial begin
        int sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: axis along z, unit radius. Origin lies on the axis.
        send_point(0, 0, 0);
        send_point(0, 0, 12345678);
        send_point(65536, 0, 0);
        send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
        send_point(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
        send_point(-64'sd2147483648, 64'sd2147483647, 0);

        // Axis along x: on-axis point takes the y-cross fallback.
        load_cylinder(64'sd2147483647, -64'sd2147483648, 0, 65536, 0, 0, 64'sd2147483647);
        send_point(0, -64'sd2147483648, 0);
        send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
        send_point(-64'sd2147483648, 0, 64'sd2147483647);

        // Zero axis: zero normal on the degenerate path.
        load_cylinder(1000, -2000, 3000, 0, 0, 0, 131072);
        send_point(1000, -2000, 3000);
        send_point(5000, 7000, -9000);

        // Extreme axis bits, far outside unit length; zero radius.
        load_cylinder(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                      131071, -131072, 131071, 0);
        send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);
        send_point(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
        send_point(0, 0, 0);

        load_cylinder(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                      -131072, 131071, -131072, 64'sd2147483647);
        send_point(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648);
        send_point(64'sd2147483647, 64'sd2147483647, 64'sd2147483647);

        // Axis along y: on-axis point takes the x-cross fallback.
        load_cylinder(0, 0, 0, 0, 65536, 0, 65536);
        send_point(0, 777777, 0);
        send_point(3, -5, 7);

        // Random part: pacing of the sender changes by thirds.
        sent = 0;
        for (int s = 0; s < SHAPES; s++) begin
            load_random_cylinder();
            for (int k = 0; k < ITEMS_PER_SHAPE; k++) begin
                idle_pct = (sent < SHAPES * ITEMS_PER_SHAPE / 3) ? 21
                         : (sent < 2 * SHAPES * ITEMS_PER_SHAPE / 3) ? 48 : 0;
                send_random_point();
                sent++;
            end
        end
        i_start <= 1'b0;

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
